[rtl/fpl_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and state encoding for the fixed-point logarithm block.
package fpl_pkg;

  localparam int FRAC_W     = 16;
  localparam int NORM_STEPS = 5;    // 16, 8, 4, 2, 1 bit leading-zero search
  localparam int STEP_W     = 5;    // holds max(NORM_STEPS, FRAC_W) - 1
  localparam int NORM_TOP   = 30;   // msb of a positive 32-bit operand

  localparam logic [30:0] LN2_Q31   = 31'd1488522236;
  localparam logic [31:0] MIN_VALUE = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQUARE,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              norm_en;
    logic              sq_en;
    logic              sq_first;
    logic              scale_en;
    logic              load_out;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic is_ln;
  } status_t;

endpackage

[rtl/fixed_point_log2_ln.sv]
`timescale 1ns / 1ps
// Top level of the fixed-point log2 / natural log unit.
// Usage:
//   Drive in_command (0 = log2, 1 = ln) and in_operand, a signed value with
//   FRAC_W fraction bits, and raise start. The item is taken at a rising
//   edge where start is high and busy is low.
//   The result appears on out_log_value / out_invalid, marked by out_valid
//   high for exactly one cycle; the receiver has no way to hold it off.
//   Sequence: leading-zero search, squaring on the shared multiplier, ln2
//   scaling for ln only, then the output step. busy drops on the edge where
//   out_valid rises, so the next item cannot be taken before then.
//   A zero or negative operand skips squaring and scaling: out_invalid is set
//   and log_value is the most negative value.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and
//   drops any item in flight.
module fixed_point_log2_ln (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  output logic signed [31:0] out_log_value,
  output logic               out_invalid
);

  fpl_pkg::cmd_t    cmd;
  fpl_pkg::status_t status;

  fpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fpl_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_command    (in_command),
    .in_operand    (in_operand),
    .status        (status),
    .out_log_value (out_log_value),
    .out_invalid   (out_invalid)
  );

endmodule

[rtl/fpl_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for normalisation, squaring and natural-log scaling.
module fpl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  fpl_pkg::status_t status,
  output fpl_pkg::cmd_t    cmd,
  output logic            busy,
  output logic            out_valid
);

  fpl_pkg::state_t state_r, state_nxt;
  logic [fpl_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  localparam logic [fpl_pkg::STEP_W-1:0] NORM_LAST = fpl_pkg::STEP_W'(fpl_pkg::NORM_STEPS - 1);
  localparam logic [fpl_pkg::STEP_W-1:0] SQ_LAST   = fpl_pkg::STEP_W'(fpl_pkg::FRAC_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpl_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      fpl_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = fpl_pkg::ST_NORM;
      end
      fpl_pkg::ST_NORM: begin
        if (status.invalid) begin
          state_nxt = fpl_pkg::ST_FINISH;
        end else if (cnt_r == NORM_LAST) begin
          state_nxt = fpl_pkg::ST_SQUARE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fpl_pkg::ST_SQUARE: begin
        if (cnt_r == SQ_LAST) begin
          state_nxt = status.is_ln ? fpl_pkg::ST_SCALE : fpl_pkg::ST_FINISH;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fpl_pkg::ST_SCALE:  state_nxt = fpl_pkg::ST_FINISH;
      fpl_pkg::ST_FINISH: state_nxt = fpl_pkg::ST_IDLE;
      default:            state_nxt = fpl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.step      = cnt_r;
    busy          = 1'b1;
    out_valid_nxt = 1'b0;
    case (state_r)
      fpl_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      fpl_pkg::ST_NORM:   cmd.norm_en = !status.invalid;
      fpl_pkg::ST_SQUARE: begin
        cmd.sq_en    = 1'b1;
        cmd.sq_first = (cnt_r == '0);
      end
      fpl_pkg::ST_SCALE:  cmd.scale_en = 1'b1;
      fpl_pkg::ST_FINISH: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/fpl_datapath.sv]
`timescale 1ns / 1ps
// Datapath: leading-zero search, shared multiplier for squaring and ln2 scaling.
module fpl_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  fpl_pkg::cmd_t        cmd,
  input  logic                in_command,
  input  logic signed [31:0]  in_operand,
  output fpl_pkg::status_t     status,
  output logic signed [31:0]  out_log_value,
  output logic                out_invalid
);

  localparam int F   = fpl_pkg::FRAC_W;
  localparam int Z_W = F + 1;          // mantissa in [1,2)
  localparam int K_W = 6;              // integer part, -16..14
  localparam int Y_W = K_W + F;
  localparam logic [2*Z_W-1:0] HALF = (2*Z_W)'(1) << (F - 1);
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  logic               is_ln_r, invalid_r;
  logic [30:0]        x_r;
  logic [4:0]         lz_r;
  logic [Z_W-1:0]     z_r;
  logic [F-1:0]       frac_r;
  logic [31:0]        ln_r;
  logic signed [31:0] out_log_value_r;
  logic               out_invalid_r;

  // leading-zero search step
  logic        top_zero;
  logic [30:0] x_shift;
  logic [4:0]  amt;

  always_comb begin
    case (cmd.step[2:0])
      3'd0:    begin top_zero = (x_r[30:15] == '0); x_shift = x_r << 16; amt = 5'd16; end
      3'd1:    begin top_zero = (x_r[30:23] == '0); x_shift = x_r << 8;  amt = 5'd8;  end
      3'd2:    begin top_zero = (x_r[30:27] == '0); x_shift = x_r << 4;  amt = 5'd4;  end
      3'd3:    begin top_zero = (x_r[30:29] == '0); x_shift = x_r << 2;  amt = 5'd2;  end
      3'd4:    begin top_zero = !x_r[30];           x_shift = x_r << 1;  amt = 5'd1;  end
      default: begin top_zero = 1'b0;               x_shift = x_r;       amt = 5'd0;  end
    endcase
  end

  // integer part and saturated log2
  logic signed [K_W-1:0] k;
  logic signed [Y_W-1:0] y;
  logic signed [63:0]    y64;
  logic signed [31:0]    y_sat;

  assign k   = signed'(K_W'(fpl_pkg::NORM_TOP - F)) - signed'({1'b0, lz_r});
  assign y   = {k, frac_r};
  assign y64 = 64'(y);

  always_comb begin
    if (y64 > MAX32)      y_sat = MAX32[31:0];
    else if (y64 < MIN32) y_sat = MIN32[31:0];
    else                  y_sat = y64[31:0];
  end

  // shared multiplier
  logic [Z_W-1:0]      z_cur;
  logic signed [32:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [64:0]  product;

  assign z_cur = cmd.sq_first ? x_r[30 -: Z_W] : z_r;

  always_comb begin
    if (cmd.scale_en) begin
      mul_a = {y_sat[31], y_sat};
      mul_b = {1'b0, fpl_pkg::LN2_Q31};
    end else begin
      mul_a = 33'(z_cur);
      mul_b = 32'(z_cur);
    end
  end

  assign product = mul_a * mul_b;

  // rounded square, one fraction bit per step
  logic [2*Z_W-1:0] sq_sum;
  logic [Z_W:0]     rnd;
  logic             fbit;
  logic [Z_W-1:0]   z_nxt;

  assign sq_sum = product[2*Z_W-1:0] + HALF;
  assign rnd    = sq_sum[2*Z_W-1:F];
  assign fbit   = rnd[Z_W];
  assign z_nxt  = fbit ? rnd[Z_W:1] : rnd[Z_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_ln_r   <= 1'b0;
      invalid_r <= 1'b0;
    end else if (cmd.accept) begin
      is_ln_r   <= in_command;
      invalid_r <= in_operand[31] | (in_operand == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r  <= in_operand[30:0];
      lz_r <= '0;
    end else if (cmd.norm_en && top_zero) begin
      x_r  <= x_shift;
      lz_r <= lz_r + amt;
    end
    if (cmd.sq_en) begin
      z_r    <= z_nxt;
      frac_r <= {frac_r[F-2:0], fbit};
    end
    if (cmd.scale_en) ln_r <= product[62:31];
    if (cmd.load_out) begin
      out_invalid_r <= invalid_r;
      if (invalid_r)    out_log_value_r <= fpl_pkg::MIN_VALUE;
      else if (is_ln_r) out_log_value_r <= ln_r;
      else              out_log_value_r <= y_sat;
    end
  end

  assign status.invalid = invalid_r;
  assign status.is_ln   = is_ln_r;
  assign out_log_value  = out_log_value_r;
  assign out_invalid    = out_invalid_r;

endmodule
